FILE: rtl/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, constants and helpers for the 3x3 edge dilation fill.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int CH_BITS     = 16;
  localparam int PIX_BITS    = 4 * CH_BITS;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int DIM_BITS    = 12;
  localparam int ROW_BITS    = 12;
  localparam int CSUM_BITS   = CH_BITS + 2;
  localparam int TSUM_BITS   = CH_BITS + 4;
  localparam int RECIP_SH    = 24;
  localparam int RECIP_BITS  = RECIP_SH + 1;
  localparam int PROD_BITS   = TSUM_BITS + RECIP_BITS;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int PIPE_STAGES = 3;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 12'd1024;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_BITS-1:0] alpha;
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } pix_t;

  // [column][row], column 2 newest
  typedef pix_t [2:0][2:0] win_t;

  // per-column covered sums of the shifted window, channel 0 red .. 2 blue
  typedef struct packed {
    pix_t                               center;
    logic                               last;
    logic [2:0][2:0][CSUM_BITS-1:0]     csum;
    logic [2:0][1:0]                    ccnt;
  } win_sum_t;

  typedef struct packed {
    logic last;
    logic filled;
    pix_t pix;
  } res_t;

  // zero acts as one, oversize clamps to the maximum
  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
                                                  input logic [DIM_BITS-1:0] vmax);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ceil(2^24 / n); exact floor division for sums below 2^20 and n up to 9
  function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] n);
    logic [RECIP_BITS-1:0] r;
    case (n)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/edf_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_mean
// Two-stage mean of the covered neighbours: total and reciprocal, then
// multiply and select between fill and pass-through.
// ----------------------------------------------------------------------------
module edf_mean (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sum_vld,
  input  edf_pkg::win_sum_t  sum_in,
  output logic               res_vld,
  output edf_pkg::res_t      res_out
);

  logic                                           s2_vld_r;
  edf_pkg::win_sum_t                              s2_sum_r;
  logic [2:0][edf_pkg::TSUM_BITS-1:0]             tot;
  logic [3:0]                                     cnt;

  logic                                           s3_vld_r;
  logic [2:0][edf_pkg::TSUM_BITS-1:0]             s3_tot_r;
  logic [edf_pkg::RECIP_BITS-1:0]                 s3_recip_r;
  logic                                           s3_none_r;
  edf_pkg::pix_t                                  s3_center_r;
  logic                                           s3_last_r;

  logic [2:0][edf_pkg::PROD_BITS-1:0]             prod;
  logic                                           fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= sum_vld;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r    <= sum_in;
    s3_tot_r    <= tot;
    s3_recip_r  <= edf_pkg::recip(cnt);
    s3_none_r   <= (cnt == 4'd0);
    s3_center_r <= s2_sum_r.center;
    s3_last_r   <= s2_sum_r.last;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = edf_pkg::TSUM_BITS'(s2_sum_r.csum[0][ch])
              + edf_pkg::TSUM_BITS'(s2_sum_r.csum[1][ch])
              + edf_pkg::TSUM_BITS'(s2_sum_r.csum[2][ch]);
    end
    cnt = 4'(s2_sum_r.ccnt[0]) + 4'(s2_sum_r.ccnt[1]) + 4'(s2_sum_r.ccnt[2]);
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = edf_pkg::PROD_BITS'(s3_tot_r[ch]) * edf_pkg::PROD_BITS'(s3_recip_r);
    end
    fill = (s3_center_r.alpha == '0) && !s3_none_r;

    res_out.last   = s3_last_r;
    res_out.filled = fill;
    res_out.pix    = s3_center_r;
    if (fill) begin
      res_out.pix.red   = prod[0][edf_pkg::RECIP_SH +: edf_pkg::CH_BITS];
      res_out.pix.green = prod[1][edf_pkg::RECIP_SH +: edf_pkg::CH_BITS];
      res_out.pix.blue  = prod[2][edf_pkg::RECIP_SH +: edf_pkg::CH_BITS];
      res_out.pix.alpha = '1;
    end
  end

  assign res_vld = s3_vld_r;

endmodule

FILE: rtl/edf_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_out_fifo
// Result queue between the non-stalling pipeline and the output stream.
// ----------------------------------------------------------------------------
module edf_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  edf_pkg::res_t                 wr_data,
  input  logic                          rd_en,
  output logic                          rd_vld,
  output edf_pkg::res_t                 rd_data,
  output logic [edf_pkg::FIFO_CW-1:0]   count
);

  edf_pkg::res_t                  store_r [edf_pkg::FIFO_DEPTH];
  logic [edf_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [edf_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [edf_pkg::FIFO_CW-1:0]    cnt_r;
  logic                           pop;

  assign rd_vld  = (cnt_r != '0);
  assign pop     = rd_en && rd_vld;
  assign rd_data = store_r[rd_ptr_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({wr_en, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/edge_dilation_fill_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_dilation_fill_3x3
// Fills empty RGBA pixels with the mean of their covered 3x3 neighbours.
// Release: a result is offered once the item releasing it has passed s1 and the
//   s2/s3 mean stages and queue (pixel p is released by item p + width + 1).
// Throughput: 1 item per cycle, set by the single line memory with one read
//   and one write per cycle; input holds off while the queue holds 5 or more.
// Reset: counters, window and queue clear; sizes return to 1024; the line
//   memory is not cleared.
// ----------------------------------------------------------------------------
module edge_dilation_fill_3x3 (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [edf_pkg::DIM_BITS-1:0]  cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [edf_pkg::PIX_BITS-1:0]  in_tdata,   // red, green, blue, alpha_in
  input  logic                          in_tuser,   // flush_item
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [edf_pkg::PIX_BITS-1:0]  out_tdata,  // red, green, blue, alpha_out
  output logic                          out_tuser,  // was_filled
  output logic                          out_tlast   // frame_last
);

  localparam int LW = 2 * edf_pkg::PIX_BITS;

  // configuration
  logic [edf_pkg::DIM_BITS-1:0]   width_r;
  logic [edf_pkg::DIM_BITS-1:0]   height_r;
  logic [edf_pkg::DIM_BITS-1:0]   w_eff;
  logic [edf_pkg::DIM_BITS-1:0]   h_eff;

  // input position
  logic [edf_pkg::COL_BITS-1:0]   in_col_r, in_col_nxt;
  logic [edf_pkg::ROW_BITS-1:0]   in_row_r, in_row_nxt;

  logic                           accept;
  logic                           restart_pre;
  logic [edf_pkg::ROW_BITS-1:0]   ir;
  logic [edf_pkg::COL_BITS-1:0]   ic;
  logic                           ignore;
  logic                           ic0;
  logic                           up_ok;
  logic                           lo_ok;
  logic                           row_in;
  logic                           res_valid;
  logic [edf_pkg::ROW_BITS-1:0]   crow;
  logic [edf_pkg::DIM_BITS-1:0]   ccol;
  logic                           res_last;
  logic                           col_wrap;

  // line memory: upper row in the top half, lower row in the bottom half
  logic [LW-1:0]                  line_mem [edf_pkg::MAX_WIDTH];
  logic [LW-1:0]                  rd_q_r;
  logic                           fwd_hit_r;
  logic [LW-1:0]                  fwd_data_r;
  logic                           wr_en;
  logic [LW-1:0]                  wr_data;
  logic [LW-1:0]                  rdata;

  // first stage after the transfer
  logic                           s1_vld_r;
  logic                           s1_act_r;
  logic                           s1_clr_r;
  logic                           s1_ic0_r;
  logic                           s1_valid_r;
  logic                           s1_last_r;
  logic                           s1_up_ok_r;
  logic                           s1_lo_ok_r;
  logic [edf_pkg::COL_BITS-1:0]   s1_addr_r;
  edf_pkg::pix_t                  s1_pix_r;

  edf_pkg::pix_t                  col_up;
  edf_pkg::pix_t                  col_lo;
  edf_pkg::win_t                  win_r, win_nxt;
  edf_pkg::win_t                  base;
  edf_pkg::win_t                  shw;
  edf_pkg::win_sum_t              wsum;
  logic                           sum_vld;

  logic                           res_vld;
  edf_pkg::res_t                  res;
  edf_pkg::res_t                  q_data;
  logic [edf_pkg::FIFO_CW-1:0]    q_count;

  // --------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= edf_pkg::DIM_RESET;
      height_r <= edf_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        edf_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        edf_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_eff = edf_pkg::eff_dim(width_r,  edf_pkg::DIM_BITS'(edf_pkg::MAX_WIDTH));
  assign h_eff = edf_pkg::eff_dim(height_r, edf_pkg::DIM_BITS'(edf_pkg::MAX_HEIGHT));

  // --------------------------------------------------------------------------
  // item decode against the input position
  assign in_tready = (q_count <= edf_pkg::FIFO_CW'(edf_pkg::FIFO_DEPTH
                                                   - edf_pkg::PIPE_STAGES - 1));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // abandon the frame when the current row exceeds the height plus one
    restart_pre = ({1'b0, in_row_r} > ({1'b0, h_eff} + 13'd1));
    ir          = restart_pre ? '0 : in_row_r;
    ic          = restart_pre ? '0 : in_col_r;
    row_in      = (ir < h_eff);
    ignore      = in_tuser && row_in;
    ic0         = (ic == '0);
    up_ok       = (ir >= 12'd2);
    lo_ok       = (ir != '0);
    if (ic0) begin
      res_valid = up_ok && ((ir - 12'd2) < h_eff);
      crow      = ir - 12'd2;
      ccol      = w_eff - 12'd1;
    end else begin
      res_valid = lo_ok && ((ir - 12'd1) < h_eff);
      crow      = ir - 12'd1;
      ccol      = {1'b0, ic} - 12'd1;
    end
    res_last = res_valid && (crow == h_eff - 12'd1) && (ccol == w_eff - 12'd1);
    col_wrap = (({1'b0, ic} + 12'd1) >= w_eff);

    if (ignore) begin
      in_col_nxt = ic;
      in_row_nxt = ir;
    end else if (res_last) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (col_wrap) begin
      in_col_nxt = '0;
      in_row_nxt = ir + 12'd1;
    end else begin
      in_col_nxt = ic + 1'b1;
      in_row_nxt = ir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      if (accept) begin
        in_col_r <= in_col_nxt;
        in_row_r <= in_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r   <= !ignore;
      s1_clr_r   <= restart_pre;
      s1_ic0_r   <= ic0;
      s1_valid_r <= res_valid;
      s1_last_r  <= res_last;
      s1_up_ok_r <= up_ok;
      s1_lo_ok_r <= lo_ok;
      s1_addr_r  <= ic;
      // past the last row the new pixel counts as empty
      s1_pix_r   <= row_in ? edf_pkg::pix_t'(in_tdata) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // line memory, read at the transfer, written back in the following cycle
  always_ff @(posedge clk) begin
    rd_q_r <= line_mem[ic];
    if (wr_en) begin
      line_mem[s1_addr_r] <= wr_data;
    end
  end

  // forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (s1_addr_r == ic);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  assign rdata   = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign col_up  = s1_up_ok_r ? edf_pkg::pix_t'(rdata[LW-1:edf_pkg::PIX_BITS]) : '0;
  assign col_lo  = s1_lo_ok_r ? edf_pkg::pix_t'(rdata[edf_pkg::PIX_BITS-1:0]) : '0;
  assign wr_en   = s1_vld_r && s1_act_r;
  assign wr_data = {col_lo, s1_pix_r};

  // --------------------------------------------------------------------------
  // window shift and per-column sums
  always_comb begin
    base      = s1_clr_r ? '0 : win_r;
    shw[0]    = base[1];
    shw[1]    = base[2];
    if (s1_ic0_r) begin
      shw[2]  = '0;
    end else begin
      shw[2][0] = col_up;
      shw[2][1] = col_lo;
      shw[2][2] = s1_pix_r;
    end

    if (!s1_vld_r) begin
      win_nxt = win_r;
    end else if (!s1_act_r) begin
      win_nxt = base;
    end else if (s1_last_r) begin
      win_nxt = '0;
    end else if (s1_ic0_r) begin
      // new row: only the first column is known
      win_nxt       = '0;
      win_nxt[2][0] = col_up;
      win_nxt[2][1] = col_lo;
      win_nxt[2][2] = s1_pix_r;
    end else begin
      win_nxt = shw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    wsum.center = shw[1][1];
    wsum.last   = s1_last_r;
    wsum.csum   = '0;
    wsum.ccnt   = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (shw[c][r].alpha != '0) begin
          wsum.csum[c][0] = wsum.csum[c][0] + edf_pkg::CSUM_BITS'(shw[c][r].red);
          wsum.csum[c][1] = wsum.csum[c][1] + edf_pkg::CSUM_BITS'(shw[c][r].green);
          wsum.csum[c][2] = wsum.csum[c][2] + edf_pkg::CSUM_BITS'(shw[c][r].blue);
          wsum.ccnt[c]    = wsum.ccnt[c] + 2'd1;
        end
      end
    end
  end

  assign sum_vld = s1_vld_r && s1_act_r && s1_valid_r;

  // --------------------------------------------------------------------------
  edf_mean u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_vld (sum_vld),
    .sum_in  (wsum),
    .res_vld (res_vld),
    .res_out (res)
  );

  edf_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld),
    .wr_data (res),
    .rd_en   (out_tready),
    .rd_vld  (out_tvalid),
    .rd_data (q_data),
    .count   (q_count)
  );

  assign out_tdata = q_data.pix;
  assign out_tuser = q_data.filled;
  assign out_tlast = q_data.last;

endmodule

FILE: sim/edf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_checker
// Watches the configuration port and both streams of the 3x3 edge dilation
// fill. Keeps its own line stores, window and counters, works out the result
// pixel each input transfer releases and compares every result transfer with
// the oldest pixel still due.
// ----------------------------------------------------------------------------
module edf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [edf_pkg::DIM_BITS-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [edf_pkg::PIX_BITS-1:0]  in_tdata,   // red, green, blue, alpha_in
  input  logic                          in_tuser,   // flush_item
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [edf_pkg::PIX_BITS-1:0]  out_tdata,  // red, green, blue, alpha_out
  input  logic                          out_tuser,  // was_filled
  input  logic                          out_tlast,  // frame_last
  output int                            mismatches,
  output int                            due_count
);
  import edf_pkg::*;

  pix_t                upper_rows [MAX_WIDTH];   // two rows above the input row
  pix_t                lower_rows [MAX_WIDTH];   // one row above
  pix_t                nbr [3][3];               // [column][row], column 2 newest
  int unsigned         in_col;
  int unsigned         in_row;
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  res_t                pixels_due [$];
  int                  fail_total = 0;

  // zero acts as one, oversize clamps
  function automatic int unsigned dim_in_use(input logic [DIM_BITS-1:0] v,
                                             input int unsigned vmax);
    if (v == '0) return 1;
    if (32'(v) > vmax) return vmax;
    return 32'(v);
  endfunction

  task automatic clear_frame();
    in_col = 0;
    in_row = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nbr[i][j] = '0;
      end
    end
  endtask

  // centre of the window, filled with the truncated mean of covered neighbours
  function automatic res_t fill_from_window(input logic last);
    res_t        r;
    int unsigned sum_r;
    int unsigned sum_g;
    int unsigned sum_b;
    int unsigned n;
    r.pix    = nbr[1][1];
    r.filled = 1'b0;
    r.last   = last;
    if (nbr[1][1].alpha != '0) return r;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n     = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (nbr[i][j].alpha != '0) begin
          sum_r += 32'(nbr[i][j].red);
          sum_g += 32'(nbr[i][j].green);
          sum_b += 32'(nbr[i][j].blue);
          n++;
        end
      end
    end
    if (n == 0) return r;
    r.pix.red   = CH_BITS'(sum_r / n);
    r.pix.green = CH_BITS'(sum_g / n);
    r.pix.blue  = CH_BITS'(sum_b / n);
    r.pix.alpha = '1;
    r.filled    = 1'b1;
    return r;
  endfunction

  task automatic dilate_item(input pix_t px, input logic flush);
    int unsigned w;
    int unsigned h;
    int unsigned ir;
    int unsigned ic;
    int unsigned crow;
    int unsigned ccol;
    pix_t        col [3];
    logic        valid;
    logic        last;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, MAX_HEIGHT);
    // height lowered by more than one below the rows already taken: abandon the frame
    if (in_row > h + 1) clear_frame();
    ir = in_row;
    ic = in_col;
    if (ic >= MAX_WIDTH) ic = 0;
    // flush inside the frame is dropped
    if (flush && ir < h) return;

    col[0] = '0;
    col[1] = '0;
    col[2] = '0;
    if (ir >= 2) col[0] = upper_rows[ic];
    if (ir >= 1) col[1] = lower_rows[ic];
    if (ir < h) col[2] = px;
    upper_rows[ic] = col[1];
    lower_rows[ic] = col[2];

    for (int r = 0; r < 3; r++) begin
      nbr[0][r] = nbr[1][r];
      nbr[1][r] = nbr[2][r];
      if (ic == 0) begin
        nbr[2][r] = '0;
      end else begin
        nbr[2][r] = col[r];
      end
    end
    if (ic == 0) begin
      valid = ir >= 2 && ir - 2 < h;
      crow  = ir - 2;
      ccol  = w - 1;
    end else begin
      valid = ir >= 1 && ir - 1 < h;
      crow  = ir - 1;
      ccol  = ic - 1;
    end
    last = valid && crow == h - 1 && ccol == w - 1;
    if (valid) pixels_due.push_back(fill_from_window(last));

    // a new row starts with only its first column in the window
    if (ic == 0) begin
      for (int r = 0; r < 3; r++) begin
        nbr[0][r] = '0;
        nbr[1][r] = '0;
        nbr[2][r] = col[r];
      end
    end

    if (ic + 1 >= w) begin
      in_col = 0;
      in_row = ir + 1;
    end else begin
      in_col = ic + 1;
      in_row = ir;
    end
    if (last) clear_frame();
  endtask

  task automatic check_result();
    res_t want;
    pix_t got;
    got = pix_t'(out_tdata);
    if (pixels_due.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: result transfer with nothing due: r=%h g=%h b=%h a=%h filled=%b last=%b",
                 $time, got.red, got.green, got.blue, got.alpha, out_tuser, out_tlast);
      return;
    end
    want = pixels_due.pop_front();
    if (got.red !== want.pix.red || got.green !== want.pix.green ||
        got.blue !== want.pix.blue || got.alpha !== want.pix.alpha ||
        out_tuser !== want.filled || out_tlast !== want.last) begin
      fail_total++;
      if (fail_total <= 10) begin
        $display("%0t: expected r=%h g=%h b=%h a=%h filled=%b last=%b", $time,
                 want.pix.red, want.pix.green, want.pix.blue, want.pix.alpha,
                 want.filled, want.last);
        $display("%0t:      got r=%h g=%h b=%h a=%h filled=%b last=%b", $time,
                 got.red, got.green, got.blue, got.alpha, out_tuser, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_rows[i] = '0;
        lower_rows[i] = '0;
      end
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      clear_frame();
      pixels_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata;
        end else begin
          height_reg = cfg_wdata;
        end
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) dilate_item(pix_t'(in_tdata), in_tuser);
    end
    mismatches <= fail_total;
    due_count  <= pixels_due.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives frames of RGBA pixels through the 3x3 edge dilation fill: a short
// directed set for coverage corners, size changes and frame abandonment, then
// random frames of many sizes under several idle and stall mixes. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import edf_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic                cfg_index;
  logic [DIM_BITS-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [PIX_BITS-1:0] in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [PIX_BITS-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  int                  mismatches;
  int                  due_count;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  hold_asks;
  int                  holds_served;
  int                  hold_left;
  int                  items_sent;
  int                  cur_w;
  int                  cur_h;
  int                  target;

  edge_dilation_fill_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  edf_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    out_tready   = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != hold_asks) begin
        holds_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic pix_t rgba(input logic [CH_BITS-1:0] r, input logic [CH_BITS-1:0] g,
                                input logic [CH_BITS-1:0] b, input logic [CH_BITS-1:0] a);
    pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  function automatic pix_t random_pixel(input int empty_pct);
    pix_t p;
    case ($urandom_range(0, 15))
      0:       p = rgba('0, '0, '0, '0);
      1:       p = rgba('1, '1, '1, '0);
      default: p = rgba(CH_BITS'($urandom), CH_BITS'($urandom), CH_BITS'($urandom), '0);
    endcase
    if ($urandom_range(0, 99) >= empty_pct) begin
      case ($urandom_range(0, 7))
        0:       p.alpha = '1;
        1:       p.alpha = 16'd1;
        default: p.alpha = CH_BITS'($urandom_range(1, 65535));
      endcase
    end
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_item(input pix_t px, input logic flush);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the input until every due pixel is out, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic resize(input logic [DIM_BITS-1:0] w_val, input logic [DIM_BITS-1:0] h_val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= w_val;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h_val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // whole frame: pixels with the odd dropped flush, then the tail that drives
  // out the last row; some tail items are pixels, which the block treats as flush
  task automatic run_frame(input int w, input int h, input int empty_pct);
    for (int p = 0; p < w * h; p++) begin
      if ($urandom_range(0, 31) == 0) push_item(random_pixel(50), 1'b1);
      push_item(random_pixel(empty_pct), 1'b0);
    end
    for (int t = 0; t <= w; t++) push_item(random_pixel(50), $urandom_range(0, 3) != 0);
    items_sent += w * h + w + 1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asks     = 0;
    items_sent    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // 3x2: empty pixels with and without covered neighbours, full scale and
    // smallest coverage, truncating mean, dropped flush, pixel in the tail
    resize(12'd3, 12'd2);
    push_item(rgba(16'h1111, 16'h2222, 16'h3333, 16'h0000), 1'b0);
    push_item(rgba(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000), 1'b0);
    push_item(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    push_item(rgba(16'hDEAD, 16'hBEEF, 16'h5A5A, 16'h0000), 1'b1);
    push_item(rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    push_item(rgba(16'hABCD, 16'h1234, 16'h8000, 16'h0000), 1'b0);
    push_item(rgba(16'h0000, 16'h0000, 16'h0000, 16'h0001), 1'b0);
    push_item(rgba('0, '0, '0, '0), 1'b1);
    push_item(rgba(16'h7777, 16'h8888, 16'h9999, 16'hAAAA), 1'b0);
    push_item(rgba('0, '0, '0, '0), 1'b1);
    push_item(rgba('0, '0, '0, '0), 1'b1);

    // width lowered part way through the second row
    resize(12'd4, 12'd2);
    repeat (6) push_item(random_pixel(40), 1'b0);
    resize(12'd2, 12'd2);
    push_item(random_pixel(40), 1'b0);
    repeat (3) push_item(random_pixel(50), 1'b1);

    // zero width, then height lowered below the rows taken: frame abandoned
    resize(12'd0, 12'd4);
    repeat (3) push_item(random_pixel(40), 1'b0);
    resize(12'd0, 12'd1);
    run_frame(1, 1, 50);
    cur_w = 1;
    cur_h = 1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 58; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      // long receiver hold-off while the sender keeps offering a frame big
      // enough to fill the queue and hold off the input
      cur_w = 8;
      cur_h = 4;
      resize(12'd8, 12'd4);
      hold_asks++;
      target = items_sent + 360;
      run_frame(cur_w, cur_h, 30);
      while (items_sent < target) begin
        if ($urandom_range(0, 2) == 0) begin
          cur_w = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
          cur_h = $urandom_range(1, 6);
          resize((cur_w == 1 && $urandom_range(0, 1) == 0) ? 12'd0 : DIM_BITS'(cur_w),
                 (cur_h == 1 && $urandom_range(0, 1) == 0) ? 12'd0 : DIM_BITS'(cur_h));
        end
        run_frame(cur_w, cur_h, $urandom_range(20, 70));
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    repeat (12) @(negedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/edf_pkg.sv
rtl/edf_mean.sv
rtl/edf_out_fifo.sv
rtl/edge_dilation_fill_3x3.sv
sim/edf_checker.sv
sim/tb.sv
